[hdl/pal_pkg.sv]
// ---------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Widths, operation and status codes, the per-cell command and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

    localparam int CAPACITY = 32;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  target;
        logic [ELEM_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } cell_cmd_t;

    // Lowest set bit of the match vector
    function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[hdl/pal_if.sv]
// ---------------------------------------------------------------------------
// pal_if: request and response channels of the positional array list
// Valid/ready channels; a word moves when both are high at a clock edge.
// ---------------------------------------------------------------------------
`default_nettype none

interface pal_req_if;
    logic                        valid;
    logic                        ready;
    logic [pal_pkg::OP_W-1:0]    op;
    logic signed [31:0]          value;
    logic [pal_pkg::POS_W-1:0]   position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface pal_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pal_pkg::ST_W-1:0]    status;
    logic [pal_pkg::IDX_W-1:0]   found_index;
    logic signed [31:0]          read_value;
    logic [pal_pkg::CNT_W-1:0]   length;

    modport source (output valid, output status, output found_index, output read_value,
                    output length, input ready);
    modport sink   (input valid, input status, input found_index, input read_value,
                    input length, output ready);
endinterface

`default_nettype wire

[hdl/pal_cell.sv]
// ---------------------------------------------------------------------------
// pal_cell: one slot of the list
// Holds an entry, shifts from either neighbour, and compares against the key.
// ---------------------------------------------------------------------------
`default_nettype none

module pal_cell (
    input  wire logic                       clk,
    input  wire logic [pal_pkg::IDX_W-1:0]  cell_idx,
    input  wire pal_pkg::cell_cmd_t         cmd,
    input  wire logic [pal_pkg::ELEM_W-1:0] left_entry,
    input  wire logic [pal_pkg::ELEM_W-1:0] right_entry,
    output logic [pal_pkg::ELEM_W-1:0]      entry,
    output logic                            match
);

    logic [pal_pkg::ELEM_W-1:0] entry_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ins && (cell_idx > cmd.target))
        begin
            entry_reg <= left_entry;
        end
        else if (cmd.ins && (cell_idx == cmd.target))
        begin
            entry_reg <= cmd.value;
        end
        else if (cmd.del && (cell_idx >= cmd.target))
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;
    assign match = ({1'b0, cell_idx} < cmd.count) && (entry_reg == cmd.value);

endmodule

`default_nettype wire

[hdl/positional_array_list_unit.sv]
// ---------------------------------------------------------------------------
// positional_array_list_unit: ordered list of signed words
// Insert, delete, find and read on a row of shifting cells.
// ---------------------------------------------------------------------------
// Each request word passes through the states in order: IDLE accepts it, EVAL
// compares every cell against the key and checks the position, and DONE shifts
// the row of cells and loads the response register. DONE waits while an earlier
// response is still waiting to be taken. A new request is taken only once the
// unit is back in IDLE, so it is never taken before the last one is through.
// All cells compare and shift in parallel; the find result is the lowest
// matching slot. There is no clearing pass after reset.
`default_nettype none

module positional_array_list_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pal_req_if.sink     cmd,
    pal_rsp_if.source   rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DONE
    } state_t;

    localparam int CAP = pal_pkg::CAPACITY;
    localparam int IW  = pal_pkg::IDX_W;
    localparam int CW  = pal_pkg::CNT_W;
    localparam int EW  = pal_pkg::ELEM_W;

    state_t                    state_reg;
    pal_pkg::op_t              op_reg;
    logic [EW-1:0]             value_reg;
    logic [pal_pkg::POS_W-1:0] pos_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CAP-1:0]            match_reg;
    logic [EW-1:0]             rdata_reg;
    logic [EW-1:0]             rdata_next;
    pal_pkg::status_t          status_reg;
    pal_pkg::status_t          status_next;
    pal_pkg::status_t          final_status;

    logic                      out_valid_reg;
    pal_pkg::status_t          out_status_reg;
    logic [IW-1:0]             out_index_reg;
    logic [EW-1:0]             out_rdata_reg;
    logic [CW-1:0]             out_length_reg;

    logic [EW-1:0]             entry_w [CAP];
    logic [CAP-1:0]            match_w;
    pal_pkg::cell_cmd_t        cell_cmd;
    logic                      commit;
    logic [IW:0]               pos_ext;
    logic [IW:0]               cnt_ext;

    // ---- cell row ----
    assign commit = (state_reg == S_DONE) && !out_valid_reg;

    always_comb
    begin
        cell_cmd.ins    = commit && (op_reg == pal_pkg::OP_INSERT) &&
                          (status_reg == pal_pkg::ST_OK);
        cell_cmd.del    = commit && (op_reg == pal_pkg::OP_DELETE) &&
                          (status_reg == pal_pkg::ST_OK);
        cell_cmd.target = IW'(pos_reg - pal_pkg::POS_W'(1));
        cell_cmd.value  = value_reg;
        cell_cmd.count  = count_reg;
    end

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic [EW-1:0] left_w;
        logic [EW-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry_w[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry_w[i+1];
        end

        pal_cell u_cell (
            .clk         (clk),
            .cell_idx    (IW'(i)),
            .cmd         (cell_cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .match       (match_w[i])
        );
    end

    // ---- position checks ----
    assign pos_ext = (IW + 1)'(pos_reg);
    assign cnt_ext = (IW + 1)'(count_reg);

    always_comb
    begin
        status_next = pal_pkg::ST_OK;
        rdata_next  = '0;
        case (op_reg)
            pal_pkg::OP_INSERT:
            begin
                if (count_reg >= CW'(CAP))
                begin
                    status_next = pal_pkg::ST_FULL;
                end
                else if ((pos_reg == '0) || (pos_ext > cnt_ext + (IW + 1)'(1)))
                begin
                    status_next = pal_pkg::ST_BADPOS;
                end
            end
            pal_pkg::OP_DELETE:
            begin
                if ((pos_reg == '0) || (pos_ext > cnt_ext))
                begin
                    status_next = pal_pkg::ST_BADPOS;
                end
            end
            pal_pkg::OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = pal_pkg::ST_BADPOS;
                end
                else
                begin
                    rdata_next = entry_w[pos_reg[IW-1:0]];
                end
            end
            default:
            begin
                status_next = pal_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        final_status = status_reg;
        count_next   = count_reg;
        if ((op_reg == pal_pkg::OP_FIND) && (match_reg == '0))
        begin
            final_status = pal_pkg::ST_NOTFOUND;
        end
        if (status_reg == pal_pkg::ST_OK)
        begin
            if (op_reg == pal_pkg::OP_INSERT)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (op_reg == pal_pkg::OP_DELETE)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    // ---- sequencer and response register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        op_reg    <= pal_pkg::op_t'(cmd.op);
                        value_reg <= EW'(cmd.value);
                        pos_reg   <= cmd.position;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    match_reg  <= match_w;
                    status_reg <= status_next;
                    rdata_reg  <= rdata_next;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (commit)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= final_status;
                        out_index_reg  <= (final_status == pal_pkg::ST_OK &&
                                           op_reg == pal_pkg::OP_FIND) ?
                                          pal_pkg::first_set(match_reg) : '0;
                        out_rdata_reg  <= rdata_reg;
                        out_length_reg <= count_next;
                        count_reg      <= count_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_index = out_index_reg;
    assign rsp.read_value  = out_rdata_reg;
    assign rsp.length      = out_length_reg;

endmodule

`default_nettype wire

[hdl/pal_checker.sv]
// ---------------------------------------------------------------------------
// pal_checker: port-level checks for the positional array list
// Watches the request and response channels; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pal_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [pal_pkg::ST_W-1:0]   rsp_status,
    input wire logic [pal_pkg::IDX_W-1:0]  rsp_index,
    input wire logic [31:0]                rsp_rdata,
    input wire logic [pal_pkg::CNT_W-1:0]  rsp_length
);

    // A waiting response word stays until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_length_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_length <= pal_pkg::CNT_W'(pal_pkg::CAPACITY))
        else $error("length beyond capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == pal_pkg::ST_FULL) |->
        rsp_length == pal_pkg::CNT_W'(pal_pkg::CAPACITY))
        else $error("full status with room left");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != pal_pkg::ST_OK) |->
        (rsp_rdata == '0) && (rsp_index == '0))
        else $error("failed operation carries data");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (cmd.valid),
    .req_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_index  (rsp.found_index),
    .rsp_rdata  (rsp.read_value),
    .rsp_length (rsp.length)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: bench for the positional array list unit
// A scoreboard keeps its own copy of the list and predicts one response word
// per accepted request; both channels idle and stall at random, with one long
// response hold-off that backs the unit up.
// ---------------------------------------------------------------------------

module tb_top;

    localparam int RANDOM_WORDS = 1850;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        pal_pkg::status_t          status;
        logic [pal_pkg::IDX_W-1:0] found_index;
        logic [31:0]               read_value;
        logic [pal_pkg::CNT_W-1:0] length;
    } list_result_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} load_mode_t;

    class list_scoreboard;
        logic [31:0]  cells[$];
        list_result_t outstanding[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        // Apply one request to the shadow list and queue the response it gives
        function void note_request(pal_pkg::op_t op, logic [31:0] v,
                                   logic [pal_pkg::POS_W-1:0] p);
            list_result_t r;
            int           n;
            n = cells.size();
            r.status      = pal_pkg::ST_OK;
            r.found_index = '0;
            r.read_value  = '0;
            case (op)
                pal_pkg::OP_INSERT:
                begin
                    // full is checked before the position
                    if (n >= pal_pkg::CAPACITY)
                        r.status = pal_pkg::ST_FULL;
                    else if (p < 1 || p > n + 1)
                        r.status = pal_pkg::ST_BADPOS;
                    else
                        cells.insert(p - 1, v);
                end
                pal_pkg::OP_DELETE:
                begin
                    if (p < 1 || p > n)
                        r.status = pal_pkg::ST_BADPOS;
                    else
                        cells.delete(p - 1);
                end
                pal_pkg::OP_FIND:
                begin
                    r.status = pal_pkg::ST_NOTFOUND;
                    for (int i = 0; i < n; i++)
                    begin
                        if (cells[i] == v)
                        begin
                            r.status      = pal_pkg::ST_OK;
                            r.found_index = pal_pkg::IDX_W'(i);
                            break;
                        end
                    end
                end
                default:
                begin
                    if (p >= n)
                        r.status = pal_pkg::ST_BADPOS;
                    else
                        r.read_value = cells[p];
                end
            endcase
            r.length = pal_pkg::CNT_W'(cells.size());
            outstanding.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t w;
            if (outstanding.size() == 0)
            begin
                $error("response word with no request outstanding");
                errors++;
                return;
            end
            w = outstanding.pop_front();
            if (got.status !== w.status)
            begin
                $error("status mismatch: expected %0d, got %0d", w.status, got.status);
                errors++;
            end
            if (got.found_index !== w.found_index)
            begin
                $error("found_index mismatch: expected %0d, got %0d",
                       w.found_index, got.found_index);
                errors++;
            end
            if (got.read_value !== w.read_value)
            begin
                $error("read_value mismatch: expected %0d, got %0d",
                       $signed(w.read_value), $signed(got.read_value));
                errors++;
            end
            if (got.length !== w.length)
            begin
                $error("length mismatch: expected %0d, got %0d", w.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pal_req_if cmd_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard sb = new();
    int             results_taken = 0;
    int             idle_cycles   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Monitor, scoreboard hooks and watchdog
    always @(posedge clk)
    begin
        list_result_t got;
        if (rst_n === 1'b1)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_request(pal_pkg::op_t'(cmd_ch.op), cmd_ch.value, cmd_ch.position);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status      = pal_pkg::status_t'(rsp_ch.status);
                got.found_index = rsp_ch.found_index;
                got.read_value  = rsp_ch.read_value;
                got.length      = rsp_ch.length;
                sb.check_result(got);
                results_taken++;
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Response side: random stalls, a calm stretch, and one long hold-off
    initial
    begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_taken >= 500)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall = (results_taken >= 1000 && results_taken < 1250) ? 0 : gap_len();
            end
        end
    end

    task automatic send_word(input pal_pkg::op_t op, input logic [31:0] v,
                             input logic [pal_pkg::POS_W-1:0] p, input int gap);
        cmd_ch.valid    <= 1'b1;
        cmd_ch.op       <= op;
        cmd_ch.value    <= v;
        cmd_ch.position <= p;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Mostly in-range positions, and values that are often already held, so finds hit
    task automatic make_word(input load_mode_t mode, output pal_pkg::op_t op,
                             output logic [31:0] v,
                             output logic [pal_pkg::POS_W-1:0] p);
        int n;
        int r;
        n = sb.cells.size();
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  op = (r < 70) ? pal_pkg::OP_INSERT :
                             (r < 80) ? pal_pkg::OP_DELETE :
                             (r < 90) ? pal_pkg::OP_FIND : pal_pkg::OP_READ;
            MODE_DRAIN: op = (r < 70) ? pal_pkg::OP_DELETE :
                             (r < 80) ? pal_pkg::OP_INSERT :
                             (r < 90) ? pal_pkg::OP_FIND : pal_pkg::OP_READ;
            default:    op = pal_pkg::op_t'($urandom_range(0, 3));
        endcase

        r = $urandom_range(0, 99);
        if (r < 15 || op == pal_pkg::OP_FIND)
            p = pal_pkg::POS_W'($urandom_range(0, 63));
        else if (op == pal_pkg::OP_INSERT)
            p = pal_pkg::POS_W'($urandom_range(1, n + 1));
        else if (op == pal_pkg::OP_DELETE)
            p = (n == 0) ? pal_pkg::POS_W'(1) : pal_pkg::POS_W'($urandom_range(1, n));
        else
            p = (n == 0) ? '0 : pal_pkg::POS_W'($urandom_range(0, n - 1));

        r = $urandom_range(0, 99);
        if (r < 35 && n > 0)
            v = sb.cells[$urandom_range(0, n - 1)];
        else if (r < 70)
            v = 32'($urandom_range(0, 8)) - 32'd4;
        else if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        else
            v = $urandom;
    endtask

    initial
    begin
        pal_pkg::op_t              op;
        logic [31:0]               v;
        logic [pal_pkg::POS_W-1:0] p;
        load_mode_t                mode;

        cmd_ch.valid    = 1'b0;
        cmd_ch.op       = pal_pkg::OP_INSERT;
        cmd_ch.value    = '0;
        cmd_ch.position = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list
        send_word(pal_pkg::OP_READ,   32'd0,          6'd0,  gap_len());
        send_word(pal_pkg::OP_DELETE, 32'd0,          6'd1,  gap_len());
        send_word(pal_pkg::OP_FIND,   32'd0,          6'd0,  gap_len());
        send_word(pal_pkg::OP_INSERT, 32'd9,          6'd0,  gap_len());
        send_word(pal_pkg::OP_INSERT, 32'd9,          6'd2,  gap_len());
        // build [-1, 0, min, max, -1]
        send_word(pal_pkg::OP_INSERT, 32'h8000_0000,  6'd1,  gap_len());
        send_word(pal_pkg::OP_INSERT, 32'h7fff_ffff,  6'd2,  gap_len());
        send_word(pal_pkg::OP_INSERT, 32'hffff_ffff,  6'd1,  gap_len());
        send_word(pal_pkg::OP_INSERT, 32'd0,          6'd2,  gap_len());
        send_word(pal_pkg::OP_INSERT, 32'hffff_ffff,  6'd5,  gap_len());
        send_word(pal_pkg::OP_INSERT, 32'd5,          6'd63, gap_len());
        // duplicate: first match wins
        send_word(pal_pkg::OP_FIND,   32'hffff_ffff,  6'd0,  gap_len());
        send_word(pal_pkg::OP_FIND,   32'h7fff_ffff,  6'd63, gap_len());
        send_word(pal_pkg::OP_FIND,   32'd12345,      6'd0,  gap_len());
        send_word(pal_pkg::OP_READ,   32'd0,          6'd0,  gap_len());
        send_word(pal_pkg::OP_READ,   32'd0,          6'd4,  gap_len());
        send_word(pal_pkg::OP_READ,   32'd0,          6'd5,  gap_len());
        send_word(pal_pkg::OP_READ,   32'd0,          6'd63, gap_len());
        send_word(pal_pkg::OP_DELETE, 32'd0,          6'd0,  gap_len());
        send_word(pal_pkg::OP_DELETE, 32'd0,          6'd6,  gap_len());
        send_word(pal_pkg::OP_DELETE, 32'd0,          6'd63, gap_len());
        send_word(pal_pkg::OP_DELETE, 32'd0,          6'd1,  gap_len());
        send_word(pal_pkg::OP_DELETE, 32'd0,          6'd4,  gap_len());
        send_word(pal_pkg::OP_DELETE, 32'd0,          6'd2,  gap_len());

        mode = MODE_FILL;
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            // a new load mode is picked at random every 80 words, to push the list toward full or empty
            if (k % 80 == 0)
                mode = load_mode_t'($urandom_range(0, 2));
            make_word(mode, op, v, p);
            send_word(op, v, p, (k >= 700 && k < 900) ? 0 : gap_len());
        end
        cmd_ch.valid <= 1'b0;

        while (sb.outstanding.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
